/* hw/rtl/aqi_pkg.sv */
// shared types, widths and breakpoint tables for the air quality index core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package aqi_pkg;

    // field widths
    localparam int CONC_W      = 16;
    localparam int AQI_W       = 9;
    localparam int BAND_ROWS   = 6;
    localparam int BAND_W      = 3;
    localparam int OFF_W       = 8;
    localparam int DIFF_W      = 8;
    localparam int PROD_W      = 16;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = 21;
    localparam int MUL_W       = PROD_W + RECIP_W;
    localparam int QUO_W       = 8;

    // default number of searched bands
    localparam int LEVELS_DEF = 6;

    localparam logic [AQI_W-1:0] AQI_MAX = 9'd500;
    localparam longint RECIP_ONE = 64'd1 << RECIP_SHIFT;

    // concentration breakpoints
    localparam logic [CONC_W-1:0] PM25_LO [BAND_ROWS] = '{
        16'd0, 16'd13, 16'd36, 16'd56, 16'd151, 16'd251};
    localparam logic [CONC_W-1:0] PM25_HI [BAND_ROWS] = '{
        16'd12, 16'd35, 16'd55, 16'd150, 16'd250, 16'd500};
    localparam logic [CONC_W-1:0] PM10_LO [BAND_ROWS] = '{
        16'd0, 16'd55, 16'd155, 16'd255, 16'd355, 16'd425};
    localparam logic [CONC_W-1:0] PM10_HI [BAND_ROWS] = '{
        16'd54, 16'd154, 16'd254, 16'd354, 16'd424, 16'd604};

    // index breakpoints: low end and width of each band
    localparam logic [AQI_W-1:0] IDX_LO [BAND_ROWS] = '{
        9'd0, 9'd51, 9'd101, 9'd151, 9'd201, 9'd301};
    localparam logic [DIFF_W-1:0] IDX_DIFF [BAND_ROWS] = '{
        8'd50, 8'd49, 8'd49, 8'd49, 8'd99, 8'd199};

    // rounded-up reciprocals of the concentration spans, scaled by 2^24
    // exact quotient for any product below 2^16 since every span is below 256
    localparam logic [RECIP_W-1:0] PM25_RECIP [BAND_ROWS] = '{
        RECIP_W'((RECIP_ONE + 12 - 1) / 12),
        RECIP_W'((RECIP_ONE + 22 - 1) / 22),
        RECIP_W'((RECIP_ONE + 19 - 1) / 19),
        RECIP_W'((RECIP_ONE + 94 - 1) / 94),
        RECIP_W'((RECIP_ONE + 99 - 1) / 99),
        RECIP_W'((RECIP_ONE + 249 - 1) / 249)};
    localparam logic [RECIP_W-1:0] PM10_RECIP [BAND_ROWS] = '{
        RECIP_W'((RECIP_ONE + 54 - 1) / 54),
        RECIP_W'((RECIP_ONE + 99 - 1) / 99),
        RECIP_W'((RECIP_ONE + 99 - 1) / 99),
        RECIP_W'((RECIP_ONE + 99 - 1) / 99),
        RECIP_W'((RECIP_ONE + 69 - 1) / 69),
        RECIP_W'((RECIP_ONE + 179 - 1) / 179)};

    // band found for one concentration
    typedef struct packed {
        logic               over;
        logic [AQI_W-1:0]   ilo;
        logic [DIFF_W-1:0]  diff;
        logic [OFF_W-1:0]   off;
        logic [RECIP_W-1:0] recip;
    } t_band;

    // load enables of the interpolation stages
    typedef struct packed {
        logic s2;
        logic s3;
    } t_stage_en;

    // first band whose upper bound the concentration does not exceed
    function automatic t_band band_lookup(input logic [CONC_W-1:0] conc,
                                          input logic is_pm10,
                                          input int rows);
        logic [BAND_W-1:0] sel;
        logic              found;
        logic [CONC_W-1:0] hi;
        logic [CONC_W-1:0] lo;
        t_band             res;
        found = 1'b0;
        sel   = '0;
        for (int r = BAND_ROWS - 1; r >= 0; r--) begin
            hi = is_pm10 ? PM10_HI[r] : PM25_HI[r];
            if ((r < rows) && (conc <= hi)) begin
                found = 1'b1;
                sel   = BAND_W'(r);
            end
        end
        lo        = is_pm10 ? PM10_LO[sel] : PM25_LO[sel];
        res.over  = !found;
        res.ilo   = IDX_LO[sel];
        res.diff  = IDX_DIFF[sel];
        res.off   = OFF_W'(conc - lo);
        res.recip = is_pm10 ? PM10_RECIP[sel] : PM25_RECIP[sel];
        return res;
    endfunction

endpackage

/* hw/rtl/aqi_search.sv */
// stage 1: breakpoint band search for both concentrations
// depends on aqi_pkg (band tables, t_band, band_lookup)
`timescale 1ns / 1ps

module aqi_search #(
    parameter int LEVELS = aqi_pkg::LEVELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [aqi_pkg::CONC_W-1:0] i_pm25_conc,
    input  logic [aqi_pkg::CONC_W-1:0] i_pm10_conc,
    output aqi_pkg::t_band             o_pm25,
    output aqi_pkg::t_band             o_pm10
);
    import aqi_pkg::*;

    localparam int ROWS = (LEVELS < BAND_ROWS) ? LEVELS : BAND_ROWS;

    t_band n_pm25;
    t_band n_pm10;
    t_band r_pm25;
    t_band r_pm10;

    // compare against upper bounds and pick the first hit
    always_comb begin
        n_pm25 = band_lookup(i_pm25_conc, 1'b0, ROWS);
        n_pm10 = band_lookup(i_pm10_conc, 1'b1, ROWS);
    end

    // band register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pm25 <= n_pm25;
            r_pm10 <= n_pm10;
        end
    end

    assign o_pm25 = r_pm25;
    assign o_pm10 = r_pm10;

endmodule

/* hw/rtl/aqi_interp.sv */
// stages 2 and 3: linear interpolation of one sub-index inside its band
// depends on aqi_pkg (t_band, t_stage_en, widths)
`timescale 1ns / 1ps

module aqi_interp (
    input  logic                      i_clk,
    input  aqi_pkg::t_stage_en        i_en,
    input  aqi_pkg::t_band            i_band,
    output logic [aqi_pkg::AQI_W-1:0] o_sub,
    output logic                      o_over
);
    import aqi_pkg::*;

    logic [PROD_W-1:0]  n_prod;
    logic [PROD_W-1:0]  r_prod;
    logic [RECIP_W-1:0] r_recip;
    logic [AQI_W-1:0]   r_ilo;
    logic               r_over2;
    logic [MUL_W-1:0]   mul;
    logic [QUO_W-1:0]   quo;
    logic [AQI_W-1:0]   n_sub;
    logic [AQI_W-1:0]   r_sub;
    logic               r_over3;

    // index width times offset into the band
    assign n_prod = PROD_W'(i_band.diff) * PROD_W'(i_band.off);

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_prod  <= n_prod;
            r_recip <= i_band.recip;
            r_ilo   <= i_band.ilo;
            r_over2 <= i_band.over;
        end
    end

    // truncating divide by the span through its reciprocal, then add the band base, or give AQI_MAX when over range
    assign mul   = MUL_W'(r_prod) * MUL_W'(r_recip);
    assign quo   = QUO_W'(mul >> RECIP_SHIFT);
    assign n_sub = r_over2 ? AQI_MAX : (r_ilo + AQI_W'(quo));

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_sub   <= n_sub;
            r_over3 <= r_over2;
        end
    end

    assign o_sub  = r_sub;
    assign o_over = r_over3;

endmodule

/* hw/rtl/air_quality_index_core.sv */
// air quality index from pm2.5 and pm10, four-stage pipeline
// 4 register stages: band, product, sub-index, output; o_valid comes from the output stage
// one request per cycle while i_stall is low; stage 3 holds two 16x21 reciprocal multipliers
// each stage moves up when it is empty or the stage after it moves, so bubbles close
// reset: i_rst_n synchronous, clears all stage valid bits; data registers are not reset
// depends on aqi_pkg, aqi_search, aqi_interp
`timescale 1ns / 1ps

module air_quality_index_core #(
    parameter int LEVELS = aqi_pkg::LEVELS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [aqi_pkg::CONC_W-1:0] i_pm25_conc,
    input  logic [aqi_pkg::CONC_W-1:0] i_pm10_conc,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [aqi_pkg::AQI_W-1:0]  o_aqi,
    output logic                       o_over_scale
);
    import aqi_pkg::*;

    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic r_v4;
    logic rdy1;
    logic rdy2;
    logic rdy3;
    logic rdy4;
    t_stage_en        stage_en;
    t_band            band_pm25;
    t_band            band_pm10;
    logic [AQI_W-1:0] sub_pm25;
    logic [AQI_W-1:0] sub_pm10;
    logic             over_pm25;
    logic             over_pm10;
    logic [AQI_W-1:0] n_aqi;
    logic [AQI_W-1:0] r_aqi;
    logic             r_over;

    // per-stage ready chain from the output back
    assign rdy4 = !r_v4 || !i_stall;
    assign rdy3 = !r_v3 || rdy4;
    assign rdy2 = !r_v2 || rdy3;
    assign rdy1 = !r_v1 || rdy2;
    assign o_stall = !rdy1;

    assign stage_en.s2 = rdy2;
    assign stage_en.s3 = rdy3;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
            if (rdy4) r_v4 <= r_v3;
        end
    end

    // stage 1: band search
    aqi_search #(
        .LEVELS(LEVELS)
    ) u_search (
        .i_clk      (i_clk),
        .i_en       (rdy1),
        .i_pm25_conc(i_pm25_conc),
        .i_pm10_conc(i_pm10_conc),
        .o_pm25     (band_pm25),
        .o_pm10     (band_pm10)
    );

    // stages 2 and 3: interpolation per pollutant
    aqi_interp u_interp_pm25 (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_band(band_pm25),
        .o_sub (sub_pm25),
        .o_over(over_pm25)
    );

    aqi_interp u_interp_pm10 (
        .i_clk (i_clk),
        .i_en  (stage_en),
        .i_band(band_pm10),
        .o_sub (sub_pm10),
        .o_over(over_pm10)
    );

    // stage 4: larger sub-index into the output register
    assign n_aqi = (sub_pm25 > sub_pm10) ? sub_pm25 : sub_pm10;

    always_ff @(posedge i_clk) begin
        if (rdy4) begin
            r_aqi  <= n_aqi;
            r_over <= over_pm25 || over_pm10;
        end
    end

    assign o_valid      = r_v4;
    assign o_aqi        = r_aqi;
    assign o_over_scale = r_over;

endmodule

/* hw/rtl/aqi_checker.sv */
// port-level checks for air_quality_index_core, attached by bind
// depends on aqi_pkg and the top level's port list
`timescale 1ns / 1ps

module aqi_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_valid,
    input logic                      o_stall,
    input logic                      o_valid,
    input logic                      i_stall,
    input logic [aqi_pkg::AQI_W-1:0] o_aqi,
    input logic                      o_over_scale
);
    import aqi_pkg::*;

    // reset empties the pipeline
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high after reset");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_aqi) && $stable(o_over_scale))
        else $error("stalled result changed");

    // over scale always reports the saturated index
    a_over_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_over_scale |-> o_aqi == AQI_MAX)
        else $error("over scale without saturated index");

    // an accepted request reaches o_valid when i_stall stays low behind it
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall ##1 !i_stall ##1 !i_stall |=> o_valid)
        else $error("result missing after pipeline latency");

endmodule

bind air_quality_index_core aqi_checker u_aqi_checker (.*);

/* bench/air_quality_index_core_test.sv */
// self-checking bench for air_quality_index_core: directed breakpoint edges, then random pairs
// with random idling on both sides and one long output hold-off; a scoreboard class predicts
// each result. Depends on aqi_pkg and the core RTL.
`timescale 1ns / 1ps

module air_quality_index_core_test;

    import aqi_pkg::*;

    localparam int LEVELS         = LEVELS_DEF;
    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 5;
    localparam int MAX_GAP        = 18;
    localparam int HOLD_CYCLES    = 90;
    localparam int PRESSURE_PAIRS = 40;
    localparam int RANDOM_PAIRS   = 1900;
    localparam int STYLE_SPAN     = 64;
    localparam int DRAIN_CYCLES   = 12;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;
    localparam int NUM_BANDS      = 6;
    localparam int INDEX_CEIL     = 500;

    // idling styles shared by the two sides
    typedef enum int {
        IDLE_NONE,
        IDLE_LIGHT,
        IDLE_FULL
    } idle_style_t;

    // breakpoint bands, concentration and index
    localparam int PM25_BAND_LO [NUM_BANDS] = '{0, 13, 36, 56, 151, 251};
    localparam int PM25_BAND_HI [NUM_BANDS] = '{12, 35, 55, 150, 250, 500};
    localparam int PM10_BAND_LO [NUM_BANDS] = '{0, 55, 155, 255, 355, 425};
    localparam int PM10_BAND_HI [NUM_BANDS] = '{54, 154, 254, 354, 424, 604};
    localparam int INDEX_LO     [NUM_BANDS] = '{0, 51, 101, 151, 201, 301};
    localparam int INDEX_HI     [NUM_BANDS] = '{50, 100, 150, 200, 300, 500};

    typedef struct packed {
        logic [AQI_W-1:0] aqi;
        logic             over;
    } aqi_reading_t;

    // predicts the index of each accepted request and checks results in order
    class aqi_scoreboard;
        aqi_reading_t pending[$];
        int           mismatches;

        function new();
            mismatches = 0;
        endfunction

        function void flag(string msg);
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
                $display("mismatch at %0t: %s", $realtime, msg);
        endfunction

        // interpolated sub-index of one pollutant, saturating above the searched bands
        function int unsigned sub_index(int unsigned conc, bit is_pm10, inout bit over);
            int unsigned rows;
            int unsigned clo;
            int unsigned chi;
            int unsigned v;
            rows = (LEVELS < NUM_BANDS) ? LEVELS : NUM_BANDS;
            for (int r = 0; r < rows; r++) begin
                clo = is_pm10 ? PM10_BAND_LO[r] : PM25_BAND_LO[r];
                chi = is_pm10 ? PM10_BAND_HI[r] : PM25_BAND_HI[r];
                if (conc <= chi) begin
                    v = INDEX_LO[r];
                    if (chi != clo)
                        v = INDEX_LO[r] + ((INDEX_HI[r] - INDEX_LO[r]) *
                            ((conc >= clo) ? conc - clo : 0)) / (chi - clo);
                    return (v > INDEX_CEIL) ? INDEX_CEIL : v;
                end
            end
            over = 1'b1;
            return INDEX_CEIL;
        endfunction

        function void note_request(logic [CONC_W-1:0] pm25, logic [CONC_W-1:0] pm10);
            aqi_reading_t exp_r;
            bit           over;
            int unsigned  a;
            int unsigned  b;
            over       = 1'b0;
            a          = sub_index(pm25, 1'b0, over);
            b          = sub_index(pm10, 1'b1, over);
            exp_r.aqi  = AQI_W'((a > b) ? a : b);
            exp_r.over = over;
            pending.push_back(exp_r);
        endfunction

        function void check_result(logic [AQI_W-1:0] aqi, logic over);
            aqi_reading_t exp_r;
            if (pending.size() == 0) begin
                flag($sformatf("result aqi=%0d over=%0b with no request pending", aqi, over));
                return;
            end
            exp_r = pending.pop_front();
            if (aqi !== exp_r.aqi)
                flag($sformatf("aqi expected %0d got %0d", exp_r.aqi, aqi));
            if (over !== exp_r.over)
                flag($sformatf("over_scale expected %0b got %0b", exp_r.over, over));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               pair_valid;
    logic               pair_stall;
    logic [CONC_W-1:0]  pm25;
    logic [CONC_W-1:0]  pm10;
    logic               aqi_valid;
    logic               aqi_stall;
    logic [AQI_W-1:0]   aqi;
    logic               over_scale;

    aqi_scoreboard sb = new();
    idle_style_t   idle_style;
    bit            hold_off_req;
    int            quiet_cycles;

    air_quality_index_core #(
        .LEVELS(LEVELS)
    ) i_dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (pair_valid),
        .o_stall      (pair_stall),
        .i_pm25_conc  (pm25),
        .i_pm10_conc  (pm10),
        .o_valid      (aqi_valid),
        .i_stall      (aqi_stall),
        .o_aqi        (aqi),
        .o_over_scale (over_scale)
    );

    // clock
    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    function automatic int draw_gap();
        case (idle_style)
            IDLE_NONE:  return 0;
            IDLE_LIGHT: return $urandom_range(0, 2);
            default:    return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    // mostly in-range pairs, with edges, wide values and over-scale mixed in
    function automatic void draw_pair(output logic [CONC_W-1:0] a, output logic [CONC_W-1:0] b);
        int kind;
        kind = $urandom_range(0, 9);
        a    = CONC_W'($urandom_range(0, 520));
        b    = CONC_W'($urandom_range(0, 620));
        case (kind)
            6: begin
                a = CONC_W'($urandom);
                b = CONC_W'($urandom);
            end
            7: begin
                a = CONC_W'(PM25_BAND_HI[$urandom_range(0, NUM_BANDS - 1)] +
                            $urandom_range(0, 1));
                b = CONC_W'(PM10_BAND_HI[$urandom_range(0, NUM_BANDS - 1)] +
                            $urandom_range(0, 1));
            end
            8: begin
                a = CONC_W'($urandom_range(0, 60));
                b = CONC_W'($urandom_range(0, 160));
            end
            9: begin
                if ($urandom_range(0, 1))
                    a = CONC_W'($urandom_range(501, 65535));
                else
                    b = CONC_W'($urandom_range(605, 65535));
            end
            default: ;
        endcase
    endfunction

    // offer one request after a gap and hold it until accepted
    task automatic send_pair(input logic [CONC_W-1:0] a, input logic [CONC_W-1:0] b,
                             input int gap);
        if (gap > 0) begin
            pair_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pair_valid <= 1'b1;
        pm25       <= a;
        pm10       <= b;
        @(posedge clk);
        while (pair_stall) @(posedge clk);
    endtask

    // result side: stall for a drawn number of cycles, or for the long hold-off when requested, then take one result
    initial begin : result_side
        int hold;
        aqi_stall <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req) begin
                hold_off_req = 1'b0;
                hold         = HOLD_CYCLES;
            end else begin
                hold = draw_gap();
            end
            if (hold > 0) begin
                aqi_stall <= 1'b1;
                repeat (hold) @(posedge clk);
                aqi_stall <= 1'b0;
            end
            @(posedge clk);
            while (!aqi_valid) @(posedge clk);
        end
    end

    // handshake monitor and watchdog
    always @(posedge clk) begin : monitor
        logic moved;
        moved = 1'b0;
        if (rst_n) begin
            if (pair_valid && !pair_stall) begin
                sb.note_request(pm25, pm10);
                moved = 1'b1;
            end
            if (aqi_valid && !aqi_stall) begin
                sb.check_result(aqi, over_scale);
                moved = 1'b1;
            end
        end
        quiet_cycles = moved ? 0 : quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin : stimulus
        int                edge25 [12];
        int                edge10 [12];
        logic [CONC_W-1:0] a;
        logic [CONC_W-1:0] b;
        edge25       = '{12, 13, 35, 36, 55, 56, 150, 151, 250, 251, 500, 501};
        edge10       = '{54, 55, 154, 155, 254, 255, 354, 355, 424, 425, 604, 605};
        quiet_cycles = 0;
        hold_off_req = 1'b0;
        idle_style   = IDLE_FULL;
        rst_n        <= 1'b0;
        pair_valid   <= 1'b0;
        pm25         <= '0;
        pm10         <= '0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: zero, all ones, both sides of every breakpoint
        send_pair('0, '0, draw_gap());
        send_pair('1, '1, draw_gap());
        foreach (edge25[k]) send_pair(CONC_W'(edge25[k]), '0, draw_gap());
        foreach (edge10[k]) send_pair('0, CONC_W'(edge10[k]), draw_gap());

        // long output hold-off while requests keep coming back to back
        idle_style   = IDLE_NONE;
        hold_off_req = 1'b1;
        repeat (PRESSURE_PAIRS) begin
            draw_pair(a, b);
            send_pair(a, b, 0);
        end

        // random pairs, idling style is redrawn every span
        for (int n = 0; n < RANDOM_PAIRS; n++) begin
            if (n % STYLE_SPAN == 0)
                idle_style = idle_style_t'($urandom_range(0, 3) > 1 ? IDLE_FULL :
                                           $urandom_range(0, 1) ? IDLE_LIGHT : IDLE_NONE);
            draw_pair(a, b);
            send_pair(a, b, draw_gap());
        end
        pair_valid <= 1'b0;

        // drain
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
